/* rtl/core/market_fill_simulator_assert.svh */
// assertion macros used by the fill simulator back end
`ifndef MARKET_FILL_SIMULATOR_ASSERT_SVH
`define MARKET_FILL_SIMULATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MFS_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mfs_pkg.sv */
// shared types and codes for the fill simulator
package mfs_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [DATA_W-1:0] FIRST_ID_RESET = 32'd1;

   // request function codes
   localparam logic [1:0] FUNC_BOOK   = 2'd0;
   localparam logic [1:0] FUNC_TRADE  = 2'd1;
   localparam logic [1:0] FUNC_NEW    = 2'd2;
   localparam logic [1:0] FUNC_CANCEL = 2'd3;

   // result kind codes
   localparam logic [2:0] KIND_BOOK_CANCEL = 3'd0;
   localparam logic [2:0] KIND_BOOK_ADD    = 3'd1;
   localparam logic [2:0] KIND_PRINT       = 3'd2;
   localparam logic [2:0] KIND_ACCEPTED    = 3'd3;
   localparam logic [2:0] KIND_CANCELED    = 3'd4;
   localparam logic [2:0] KIND_FILLED      = 3'd5;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef struct packed {
      logic [1:0]        func;
      logic              side;
      logic [DATA_W-1:0] own_id;
      logic [DATA_W-1:0] price;
      logic [DATA_W-1:0] qty;
      logic              bid_valid;
      logic [DATA_W-1:0] bid_px;
      logic [DATA_W-1:0] bid_qty;
      logic              ask_valid;
      logic [DATA_W-1:0] ask_px;
      logic [DATA_W-1:0] ask_qty;
   } req_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic              out_side;
      logic [DATA_W-1:0] out_id;
      logic [DATA_W-1:0] out_price;
      logic [DATA_W-1:0] exec_qty;
      logic [DATA_W-1:0] leaves_qty;
      logic              last;
   } rsp_type;

endpackage

/* rtl/core/mfs_front.sv */
// front end: takes request beats, normalizes the book fields, queues them
module mfs_front #(
   parameter int unsigned QueueDepth = mfs_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mfs_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_pop,
   output mfs_pkg::req_type q_data
);

   localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntW = $clog2(QueueDepth + 1);

   mfs_pkg::req_type queue_mem [QueueDepth];
   mfs_pkg::req_type norm;

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push;
   logic            pop;

   // an absent book side is carried with price and quantity zero
   always_comb begin
      norm = req_data;
      if (!req_data.bid_valid) begin
         norm.bid_px  = '0;
         norm.bid_qty = '0;
      end
      if (!req_data.ask_valid) begin
         norm.ask_px  = '0;
         norm.ask_qty = '0;
      end
   end

   assign req_ready = (count_ff < CntW'(QueueDepth));
   assign q_valid   = (count_ff != '0);
   assign q_data    = queue_mem[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= norm;
      end
   end

endmodule

/* rtl/core/mfs_back.sv */
// back end: holds book and order state, sequences result beats
`include "market_fill_simulator_assert.svh"

module mfs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_pop,
   input  mfs_pkg::req_type           q_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mfs_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mfs_pkg::DATA_W-1:0] csr_data
);

   localparam int unsigned W = mfs_pkg::DATA_W;

   // step bits, lowest pending goes out first
   localparam int unsigned STEP_SINGLE   = 0;
   localparam int unsigned STEP_BID_CXL  = 1;
   localparam int unsigned STEP_ASK_CXL  = 2;
   localparam int unsigned STEP_BID_ADD  = 3;
   localparam int unsigned STEP_ASK_ADD  = 4;
   localparam int unsigned STEP_BID_FILL = 5;
   localparam int unsigned STEP_ASK_FILL = 6;
   localparam int unsigned STEPS         = 7;

   // live own orders
   logic [1:0][W-1:0] live_id_ff, live_id_in;
   logic [1:0][W-1:0] live_px_ff, live_px_in;
   logic [1:0][W-1:0] live_lv_ff, live_lv_in;
   // stored top of book and resting synthetic orders
   logic [1:0]        book_v_ff, book_v_in;
   logic [1:0][W-1:0] book_px_ff, book_px_in;
   logic [1:0][W-1:0] book_qt_ff, book_qt_in;
   logic [1:0]        rest_v_ff, rest_v_in;
   logic [1:0][W-1:0] rest_id_ff, rest_id_in;
   logic [W-1:0]      next_id_ff, next_id_in;
   // work held for the item in progress
   logic [STEPS-1:0]  work_mask_ff, work_mask_in;
   logic [2:0]        s_kind_ff, s_kind_in;
   logic              s_side_ff, s_side_in;
   logic [W-1:0]      s_id_ff, s_id_in;
   logic [W-1:0]      s_px_ff, s_px_in;
   logic [W-1:0]      s_exec_ff, s_exec_in;
   logic [W-1:0]      s_leaves_ff, s_leaves_in;
   logic [1:0][W-1:0] c_id_ff, c_id_in;
   logic [1:0][W-1:0] c_px_ff, c_px_in;
   logic [1:0][W-1:0] c_qty_ff, c_qty_in;
   logic [1:0][W-1:0] fill_px_ff, fill_px_in;
   logic [1:0][W-1:0] fill_av_ff, fill_av_in;
   // output stage
   logic              rsp_valid_ff, rsp_valid_in;
   mfs_pkg::rsp_type  rsp_ff, rsp_in;

   logic              start;
   logic              emit;
   logic              sel;
   logic [STEPS-1:0]  lowbit;
   logic [STEPS-1:0]  rest_mask;
   logic [1:0]        nv;
   logic [1:0][W-1:0] np;
   logic [1:0][W-1:0] nq;
   logic [1:0]        chg;
   logic [1:0]        add;
   logic [1:0]        cxl;
   logic [1:0]        book_fill;
   logic [1:0]        trade_fill;
   logic [1:0][W-1:0] add_id;
   logic [1:0][W-1:0] fill_q;
   logic [1:0][W-1:0] fill_left;

   assign start     = q_valid && (work_mask_ff == '0);
   assign q_pop     = start;
   assign emit      = (work_mask_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign lowbit    = work_mask_ff & (~work_mask_ff + STEPS'(1));
   assign rest_mask = work_mask_ff & ~lowbit;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign nv    = {q_data.ask_valid, q_data.bid_valid};
   assign np[0] = q_data.bid_px;
   assign np[1] = q_data.ask_px;
   assign nq[0] = q_data.bid_qty;
   assign nq[1] = q_data.ask_qty;

   assign add_id[0] = next_id_ff;
   assign add_id[1] = next_id_ff + W'(add[0]);

   // per side classification of the item at the queue head
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         chg[s] = (nv[s] != book_v_ff[s]) ||
                  (nv[s] && ((np[s] != book_px_ff[s]) || (nq[s] != book_qt_ff[s])));
         add[s] = chg[s] && nv[s];
         cxl[s] = chg[s] && rest_v_ff[s];
      end
      book_fill[0]  = (live_lv_ff[0] != '0) && nv[1] && (live_px_ff[0] >= np[1]);
      book_fill[1]  = (live_lv_ff[1] != '0) && nv[0] && (live_px_ff[1] <= np[0]);
      trade_fill[0] = (live_lv_ff[0] != '0) && (q_data.price <= live_px_ff[0]) &&
                      (q_data.qty != '0);
      trade_fill[1] = (live_lv_ff[1] != '0) && (q_data.price >= live_px_ff[1]) &&
                      (q_data.qty != '0);
   end

   // fill quantity against the live order of each side
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         fill_q[s]    = (live_lv_ff[s] < fill_av_ff[s]) ? live_lv_ff[s] : fill_av_ff[s];
         fill_left[s] = live_lv_ff[s] - fill_q[s];
      end
   end

   // state update at item start, one result beat per step after that
   always_comb begin
      live_id_in   = live_id_ff;
      live_px_in   = live_px_ff;
      live_lv_in   = live_lv_ff;
      book_v_in    = book_v_ff;
      book_px_in   = book_px_ff;
      book_qt_in   = book_qt_ff;
      rest_v_in    = rest_v_ff;
      rest_id_in   = rest_id_ff;
      next_id_in   = next_id_ff;
      work_mask_in = work_mask_ff;
      s_kind_in    = s_kind_ff;
      s_side_in    = s_side_ff;
      s_id_in      = s_id_ff;
      s_px_in      = s_px_ff;
      s_exec_in    = s_exec_ff;
      s_leaves_in  = s_leaves_ff;
      c_id_in      = c_id_ff;
      c_px_in      = c_px_ff;
      c_qty_in     = c_qty_ff;
      fill_px_in   = fill_px_ff;
      fill_av_in   = fill_av_ff;
      rsp_in       = rsp_ff;
      sel          = 1'b0;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (start) begin
         unique case (q_data.func)
            mfs_pkg::FUNC_BOOK: begin
               for (int s = 0; s < 2; s++) begin
                  c_id_in[s]    = rest_id_ff[s];
                  c_px_in[s]    = book_px_ff[s];
                  c_qty_in[s]   = book_qt_ff[s];
                  book_v_in[s]  = nv[s];
                  book_px_in[s] = np[s];
                  book_qt_in[s] = nq[s];
                  if (chg[s]) begin
                     rest_v_in[s]  = nv[s];
                     rest_id_in[s] = nv[s] ? add_id[s] : '0;
                  end
               end
               next_id_in    = next_id_ff + W'(add[0]) + W'(add[1]);
               fill_px_in[0] = np[1];
               fill_av_in[0] = nq[1];
               fill_px_in[1] = np[0];
               fill_av_in[1] = nq[0];
               work_mask_in  = {book_fill[1], book_fill[0], add[1], add[0],
                                cxl[1], cxl[0], 1'b0};
            end
            mfs_pkg::FUNC_TRADE: begin
               s_kind_in     = mfs_pkg::KIND_PRINT;
               s_side_in     = q_data.side;
               s_id_in       = '0;
               s_px_in       = q_data.price;
               s_exec_in     = q_data.qty;
               s_leaves_in   = '0;
               fill_px_in[0] = live_px_ff[0];
               fill_av_in[0] = q_data.qty;
               fill_px_in[1] = live_px_ff[1];
               fill_av_in[1] = q_data.qty;
               // buy aggressor hits the resting sell, and the reverse
               work_mask_in  = {(q_data.side == mfs_pkg::SIDE_BUY) && trade_fill[1],
                                (q_data.side == mfs_pkg::SIDE_SELL) && trade_fill[0],
                                4'b0000, 1'b1};
            end
            mfs_pkg::FUNC_NEW: begin
               live_id_in[q_data.side] = q_data.own_id;
               live_px_in[q_data.side] = q_data.price;
               live_lv_in[q_data.side] = q_data.qty;
               s_kind_in    = mfs_pkg::KIND_ACCEPTED;
               s_side_in    = q_data.side;
               s_id_in      = q_data.own_id;
               s_px_in      = q_data.price;
               s_exec_in    = '0;
               s_leaves_in  = q_data.qty;
               work_mask_in = STEPS'(1);
            end
            mfs_pkg::FUNC_CANCEL: begin
               live_id_in[q_data.side] = '0;
               live_px_in[q_data.side] = '0;
               live_lv_in[q_data.side] = '0;
               s_kind_in    = mfs_pkg::KIND_CANCELED;
               s_side_in    = q_data.side;
               s_id_in      = q_data.own_id;
               s_px_in      = q_data.price;
               s_exec_in    = '0;
               s_leaves_in  = q_data.qty;
               work_mask_in = STEPS'(1);
            end
            default: begin
               work_mask_in = '0;
            end
         endcase
      end else if (emit) begin
         work_mask_in = rest_mask;
         rsp_in.last  = (rest_mask == '0);
         priority if (work_mask_ff[STEP_SINGLE]) begin
            rsp_in.kind       = s_kind_ff;
            rsp_in.out_side   = s_side_ff;
            rsp_in.out_id     = s_id_ff;
            rsp_in.out_price  = s_px_ff;
            rsp_in.exec_qty   = s_exec_ff;
            rsp_in.leaves_qty = s_leaves_ff;
         end else if (work_mask_ff[STEP_BID_CXL] || work_mask_ff[STEP_ASK_CXL]) begin
            sel               = !work_mask_ff[STEP_BID_CXL];
            rsp_in.kind       = mfs_pkg::KIND_BOOK_CANCEL;
            rsp_in.out_side   = sel;
            rsp_in.out_id     = c_id_ff[sel];
            rsp_in.out_price  = c_px_ff[sel];
            rsp_in.exec_qty   = c_qty_ff[sel];
            rsp_in.leaves_qty = '0;
         end else if (work_mask_ff[STEP_BID_ADD] || work_mask_ff[STEP_ASK_ADD]) begin
            sel               = !work_mask_ff[STEP_BID_ADD];
            rsp_in.kind       = mfs_pkg::KIND_BOOK_ADD;
            rsp_in.out_side   = sel;
            rsp_in.out_id     = rest_id_ff[sel];
            rsp_in.out_price  = book_px_ff[sel];
            rsp_in.exec_qty   = book_qt_ff[sel];
            rsp_in.leaves_qty = book_qt_ff[sel];
         end else begin
            sel               = !work_mask_ff[STEP_BID_FILL];
            rsp_in.kind       = mfs_pkg::KIND_FILLED;
            rsp_in.out_side   = sel;
            rsp_in.out_id     = live_id_ff[sel];
            rsp_in.out_price  = fill_px_ff[sel];
            rsp_in.exec_qty   = fill_q[sel];
            rsp_in.leaves_qty = fill_left[sel];
            live_lv_in[sel]   = fill_left[sel];
            // a fully filled order is gone
            if (fill_left[sel] == '0) begin
               live_id_in[sel] = '0;
               live_px_in[sel] = '0;
            end
         end
      end

      // register write reloads the synthetic id counter
      if (csr_valid) begin
         next_id_in = csr_data;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         live_id_ff   <= '0;
         live_px_ff   <= '0;
         live_lv_ff   <= '0;
         book_v_ff    <= '0;
         book_px_ff   <= '0;
         book_qt_ff   <= '0;
         rest_v_ff    <= '0;
         rest_id_ff   <= '0;
         next_id_ff   <= mfs_pkg::FIRST_ID_RESET;
         work_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         live_id_ff   <= live_id_in;
         live_px_ff   <= live_px_in;
         live_lv_ff   <= live_lv_in;
         book_v_ff    <= book_v_in;
         book_px_ff   <= book_px_in;
         book_qt_ff   <= book_qt_in;
         rest_v_ff    <= rest_v_in;
         rest_id_ff   <= rest_id_in;
         next_id_ff   <= next_id_in;
         work_mask_ff <= work_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work and output payload
   always_ff @(posedge clock) begin
      s_kind_ff   <= s_kind_in;
      s_side_ff   <= s_side_in;
      s_id_ff     <= s_id_in;
      s_px_ff     <= s_px_in;
      s_exec_ff   <= s_exec_in;
      s_leaves_ff <= s_leaves_in;
      c_id_ff     <= c_id_in;
      c_px_ff     <= c_px_in;
      c_qty_ff    <= c_qty_in;
      fill_px_ff  <= fill_px_in;
      fill_av_ff  <= fill_av_in;
      rsp_ff      <= rsp_in;
   end

   // checks on the step sequencer
   `MFS_ASSERT_HOLDS(a_bid_fill_live, emit && lowbit[STEP_BID_FILL], live_lv_ff[0] != '0, "bid fill with no live order")
   `MFS_ASSERT_HOLDS(a_ask_fill_live, emit && lowbit[STEP_ASK_FILL], live_lv_ff[1] != '0, "ask fill with no live order")
   `MFS_ASSERT_NEXT(a_last_drains, emit && (rest_mask == '0), work_mask_ff == '0, "work left after last beat")
   `MFS_ASSERT_HOLDS(a_rest_id_clear, !rest_v_ff[0] || !rest_v_ff[1], ((rest_v_ff[0] || (rest_id_ff[0] == '0)) && (rest_v_ff[1] || (rest_id_ff[1] == '0))), "stale resting id")

endmodule

/* rtl/core/market_fill_simulator.sv */
// Fill simulator for one instrument: top-of-book updates, trade prints and own
// new/cancel orders go in on the req channel (valid/ready, one beat per item).
// Results come out on the rsp channel, one beat each, the final beat of an item
// marked with last. A book update gives 0 to 6 beats, a trade 1 or 2, a new or
// cancel order 1. The csr channel loads the first synthetic order id; write it
// only while the block is idle. csr_ready is always high.
// An accepted item is written to the queue; the execution unit takes it from
// the queue and updates book state, then sends one result beat per cycle into
// the output register while rsp is not stalled. It takes the next item only
// after the last beat of the current one.
// Requests are taken while earlier items still execute, up to QueueDepth items
// waiting in the queue between front and back.
// A stalled rsp holds its beat in the output register; the back end stops and
// the queue fills, after which req_ready drops.
// Reset clears both live orders, the stored book and resting synthetic orders,
// and sets the synthetic id counter to 1.
module market_fill_simulator #(
   parameter int unsigned QueueDepth = mfs_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  mfs_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mfs_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mfs_pkg::DATA_W-1:0] csr_data
);

   logic             q_valid;
   logic             q_pop;
   mfs_pkg::req_type q_data;

   // request intake and queue
   mfs_front #(
      .QueueDepth (QueueDepth)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_data)
   );

   // state and result sequencing
   mfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

endmodule
